// File: design/bmhq_pkg.sv
package bmhq_pkg;

  // Operation codes carried on the input tuser
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Widths of the result fields
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // One finished result, handed from the sequencer to the output register
  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;
    logic [VALUE_W-1:0] min_value;
  } result_t;

endpackage

// File: design/bmhq_key_ram.sv
module bmhq_key_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/bmhq_out_reg.sv
module bmhq_out_reg
  import bmhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     load_data,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] min_value, [38:32] entry_count, [39] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  result_t held;

  // Room for a new word when empty or when the current word leaves now
  assign free = !m_tvalid || m_tready;

  // Track the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
  end

  assign m_tdata = {1'b0, held.entry_count, held.min_value};
  assign m_tuser = held.status;

  // A word is never overwritten while it still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("output word overwritten before it was taken");

endmodule

// File: design/binary_min_heap_queue_core.sv
// Binary min-heap priority queue, keys in a one-port-read/one-port-write RAM.
// Insert: reads the parent, moves it down while the new key is smaller, then writes the key;
// a full heap gives ST_FULL. Extract: reads the root and the last entry, then per level reads
// both children and moves the smaller one up; an empty heap gives ST_EMPTY. Worst case is an
// extract that sinks to a leaf. One item in flight; ready returns the cycle after the hand-off.
// Reset (rst, synchronous, active high) empties the heap; RAM contents are not cleared.
module binary_min_heap_queue_core
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key_value
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] min_value, [38:32] entry_count, [39] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_CMP  = 4'd1;
  localparam logic [3:0] S_UP_WR   = 4'd2;
  localparam logic [3:0] S_DN_ROOT = 4'd3;
  localparam logic [3:0] S_DN_LAST = 4'd4;
  localparam logic [3:0] S_DN_CHK  = 4'd5;
  localparam logic [3:0] S_DN_LEFT = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0]                 state, state_next;
  logic [CNT_W-1:0]           count, count_next;
  logic [IDX_W-1:0]           pos, pos_next;
  logic signed [KEY_BITS-1:0] cur, cur_next;
  logic signed [KEY_BITS-1:0] left_key, left_next;
  logic                       right_ok, right_ok_next;
  logic [VALUE_W-1:0]         res_value, res_value_next;
  logic [1:0]                 res_status, res_status_next;

  logic                       wr_en, rd_en;
  logic [IDX_W-1:0]           wr_addr, rd_addr;
  logic [KEY_BITS-1:0]        wr_data;
  logic signed [KEY_BITS-1:0] rd_data;

  logic                       out_load, out_free;
  result_t                    out_word;

  logic signed [63:0]         in_ext, rd_ext;
  logic signed [KEY_BITS-1:0] in_key;
  logic [IDX_W-1:0]           cnt_idx, par_of_cnt, par_of_pos, par_of_par;
  logic [CHILD_W-1:0]         lc_w, rc_w, cnt_w;
  logic                       right_lt;
  logic signed [KEY_BITS-1:0] child_key;
  logic [IDX_W-1:0]           child_idx;
  logic [31:0]                cnt_wide;

  // Key width conversions
  assign in_ext = 64'($signed(s_tdata));
  assign in_key = in_ext[KEY_BITS-1:0];
  assign rd_ext = 64'(rd_data);

  // Heap index arithmetic
  assign cnt_idx    = count[IDX_W-1:0];
  assign par_of_cnt = (cnt_idx - IDX_W'(1)) >> 1;
  assign par_of_pos = (pos - IDX_W'(1)) >> 1;
  assign par_of_par = (par_of_pos - IDX_W'(1)) >> 1;
  assign lc_w       = CHILD_W'({pos, 1'b1});
  assign rc_w       = lc_w + CHILD_W'(1);
  assign cnt_w      = CHILD_W'(count);

  // Pick the smaller child, left on a tie
  assign right_lt  = right_ok && (rd_data < left_key);
  assign child_key = right_lt ? rd_data : left_key;
  assign child_idx = right_lt ? rc_w[IDX_W-1:0] : lc_w[IDX_W-1:0];

  assign s_tready = (state == S_IDLE);

  // Sequence the RAM accesses of one operation
  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    cur_next        = cur;
    left_next       = left_key;
    right_ok_next   = right_ok;
    res_value_next  = res_value;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = cur;
    rd_en           = 1'b0;
    rd_addr         = par_of_pos;
    out_load        = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          res_status_next = ST_DONE;
          if (s_tuser == OP_INSERT) begin
            res_value_next = '0;
            if (count == CAP_CNT) begin
              res_status_next = ST_FULL;
              state_next      = S_FINISH;
            end else begin
              cur_next   = in_key;
              pos_next   = cnt_idx;
              count_next = count + CNT_W'(1);
              if (count == '0) begin
                state_next = S_UP_WR;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = par_of_cnt;
                state_next = S_UP_CMP;
              end
            end
          end else begin
            if (count == '0) begin
              res_value_next  = '1;
              res_status_next = ST_EMPTY;
              state_next      = S_FINISH;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              count_next = count - CNT_W'(1);
              state_next = S_DN_ROOT;
            end
          end
        end
      end
      S_UP_CMP: begin
        if (cur < rd_data) begin
          // Move the parent down into the hole and climb
          wr_en    = 1'b1;
          wr_data  = rd_data;
          pos_next = par_of_pos;
          if (par_of_pos == '0) begin
            state_next = S_UP_WR;
          end else begin
            rd_en   = 1'b1;
            rd_addr = par_of_par;
          end
        end else begin
          wr_en      = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_UP_WR: begin
        wr_en      = 1'b1;
        state_next = S_FINISH;
      end
      S_DN_ROOT: begin
        res_value_next = rd_ext[VALUE_W-1:0];
        rd_en          = 1'b1;
        rd_addr        = cnt_idx;
        state_next     = S_DN_LAST;
      end
      S_DN_LAST: begin
        cur_next   = rd_data;
        pos_next   = '0;
        state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (lc_w >= cnt_w) begin
          wr_en      = 1'b1;
          state_next = S_FINISH;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = lc_w[IDX_W-1:0];
          state_next = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        left_next     = rd_data;
        right_ok_next = (rc_w < cnt_w);
        rd_en         = (rc_w < cnt_w);
        rd_addr       = rc_w[IDX_W-1:0];
        state_next    = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (child_key < cur) begin
          // Move the child up into the hole and descend
          wr_en      = 1'b1;
          wr_data    = child_key;
          pos_next   = child_idx;
          state_next = S_DN_CHK;
        end else begin
          wr_en      = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    cur        <= cur_next;
    left_key   <= left_next;
    right_ok   <= right_ok_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

  assign cnt_wide             = 32'(count);
  assign out_word.min_value   = res_value;
  assign out_word.status      = res_status;
  assign out_word.entry_count = cnt_wide[COUNT_W-1:0];

  bmhq_key_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS),
    .IDX_W (IDX_W)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bmhq_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (out_word),
    .free      (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_INSERT && count != CAP_CNT)
    |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the heap by one");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && res_status == ST_EMPTY) |-> count == '0)
    else $error("empty status reported on a non-empty heap");

endmodule

// File: bench/tb_binary_min_heap_queue_core.sv
`timescale 1ns / 1ps

module tb_binary_min_heap_queue_core;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] key_value
  logic        s_tuser = OP_INSERT;   // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;   // [31:0] min_value, [38:32] entry_count, [39] zero
  logic [1:0]  m_tuser;   // [1:0] status

  // Shadow heap and the results it predicts, oldest first
  logic signed [31:0] shadow_keys [0:HEAP_DEPTH-1];
  int                 shadow_count = 0;
  result_t            pending_results [$];
  result_t            oldest_result;

  int error_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_target = 0;
  int hold_done = 0;

  binary_min_heap_queue_core #(
    .CAPACITY(HEAP_DEPTH),
    .KEY_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow heap and return the word it should produce
  function automatic result_t heap_apply(input logic op, input logic signed [31:0] key);
    result_t            res;
    int                 pos;
    int                 parent;
    int                 best;
    int                 lc;
    int                 rc;
    logic signed [31:0] tmp;
    res.min_value = '0;
    res.status    = ST_DONE;
    if (op == OP_INSERT) begin
      if (shadow_count >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = shadow_count;
        shadow_keys[pos] = key;
        shadow_count++;
        // sift up while strictly smaller than the parent
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(shadow_keys[pos] < shadow_keys[parent])) break;
          tmp = shadow_keys[pos];
          shadow_keys[pos] = shadow_keys[parent];
          shadow_keys[parent] = tmp;
          pos = parent;
        end
      end
    end else begin
      if (shadow_count == 0) begin
        res.status    = ST_EMPTY;
        res.min_value = '1;
      end else begin
        res.min_value = shadow_keys[0];
        shadow_keys[0] = shadow_keys[shadow_count-1];
        shadow_count--;
        pos = 0;
        // sift down toward the smaller child, left child on a tie
        while (pos < shadow_count) begin
          best = pos;
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (lc < shadow_count && shadow_keys[lc] < shadow_keys[best]) best = lc;
          if (rc < shadow_count && shadow_keys[rc] < shadow_keys[best]) best = rc;
          if (best == pos) break;
          tmp = shadow_keys[pos];
          shadow_keys[pos] = shadow_keys[best];
          shadow_keys[best] = tmp;
          pos = best;
        end
      end
    end
    res.entry_count = COUNT_W'(shadow_count);
    return res;
  endfunction

  // Offer one word, idling at random first, and predict it once accepted
  task automatic send_op(input logic op, input logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), heap_apply(op, key));
  endtask

  // Mostly wide random keys, some narrow ones for ties, some extremes
  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom;
    if (sel < 85) return 32'($signed($urandom_range(15)) - 8);
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (hold_done < hold_target) begin
      m_tready  <= 1'b0;
      hold_done <= hold_done + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: min_value %0d status %0d entry_count %0d",
               $signed(m_tdata[31:0]), m_tuser, m_tdata[38:32]);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_tdata[31:0] !== oldest_result.min_value) begin
          $error("min_value mismatch: expected %0d, got %0d",
                 $signed(oldest_result.min_value), $signed(m_tdata[31:0]));
          error_count++;
        end
        if (m_tuser !== oldest_result.status) begin
          $error("status mismatch: expected %0d, got %0d", oldest_result.status, m_tuser);
          error_count++;
        end
        if (m_tdata[38:32] !== oldest_result.entry_count) begin
          $error("entry_count mismatch: expected %0d, got %0d",
                 oldest_result.entry_count, m_tdata[38:32]);
          error_count++;
        end
      end
    end
  end

  // Empty extracts, extreme and duplicate keys, then drain in order
  task automatic test_directed_edges();
    send_op(OP_EXTRACT, 32'h0000_0000);
    send_op(OP_INSERT, 32'h0000_0000);
    send_op(OP_INSERT, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h0000_0001);
    send_op(OP_INSERT, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'h5555_5555);
    send_op(OP_INSERT, 32'hAAAA_AAAA);
    repeat (9) send_op(OP_EXTRACT, $urandom);
    send_op(OP_EXTRACT, 32'hFFFF_FFFF);
    send_op(OP_EXTRACT, 32'h7FFF_FFFF);
  endtask

  // Hold the output off for a long stretch while words keep coming
  task automatic test_output_hold_off();
    hold_target = hold_done + HOLD_OFF_CYCLES;
    repeat (30) send_op(($urandom_range(99) < 70) ? OP_INSERT : OP_EXTRACT, pick_key());
  endtask

  // Random mix with a chosen share of inserts
  task automatic test_random_mix(input int n_items, input int insert_pct);
    repeat (n_items) begin
      send_op(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT, pick_key());
    end
  endtask

  // Fill to capacity, push past it, then drain past empty
  task automatic test_fill_and_drain();
    while (shadow_count < HEAP_DEPTH) send_op(OP_INSERT, pick_key());
    repeat (3) send_op(OP_INSERT, pick_key());
    while (shadow_count > 0) send_op(OP_EXTRACT, $urandom);
    repeat (2) send_op(OP_EXTRACT, $urandom);
  endtask

  // Random traffic under one setting of source idling and receiver stalls, with an optional fill and drain
  task automatic test_idle_phase(input int idle, input int stall, input bit with_fill);
    send_idle_pct = idle;
    stall_pct     = stall;
    test_random_mix(60, 75);
    if (with_fill) test_fill_and_drain();
    test_random_mix(60, 35);
    test_random_mix(20, 50);
  endtask

  // Stop offering and let every predicted word drain out
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_output_hold_off();
    test_idle_phase(0, 0, 1'b1);
    test_idle_phase(56, 0, 1'b0);
    test_idle_phase(0, 56, 1'b0);
    test_idle_phase(29, 29, 1'b1);
    wait_for_drain();
    if (error_count == 0) begin
      $display("binary_min_heap_queue_core test passed");
    end else begin
      $display("binary_min_heap_queue_core test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("binary_min_heap_queue_core test failed");
    $finish;
  end

endmodule
